FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/core/lgnc_pkg.sv
package lgnc_pkg;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;
    localparam int COORD_W   = 6;
    localparam int COUNT_W   = 4;
    localparam int DIR_W     = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CLASSIC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRAP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIRROR  = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [DIR_W-1:0] DIR_LAST = 3'd7;

    typedef struct packed {
        logic             in_ready;
        logic             clear_en;
        logic             read_en;
        logic [DIR_W-1:0] read_dir;
        logic             load_out;
    } lgnc_cmd_t;

    typedef struct packed {
        logic query_start;
        logic query_inside;
        logic clear_last;
        logic out_free;
    } lgnc_status_t;

endpackage

FILE: rtl/core/lgnc_ctrl.sv
`include "assert_macros.svh"

module lgnc_ctrl
    import lgnc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  lgnc_status_t status,
    output lgnc_cmd_t    cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [DIR_W-1:0] dir_reg;
    logic [DIR_W-1:0] dir_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        dir_next   = dir_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.query_start)
                begin
                    dir_next   = '0;
                    state_next = status.query_inside ? ST_READ : ST_FINISH;
                end
            end
            ST_READ:
            begin
                cmd.read_en  = 1'b1;
                cmd.read_dir = dir_reg;
                dir_next     = dir_reg + DIR_W'(1);
                if (dir_reg == DIR_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.load_out = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            dir_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
        end
    end

    `ASSERT_NEXT(a_read_run_end, clk, rst_n, state_reg == ST_READ && dir_reg == DIR_LAST, state_reg == ST_DRAIN, "read run did not end after eight neighbors")
    `ASSERT_NEXT(a_query_enter, clk, rst_n, status.query_start && status.query_inside, state_reg == ST_READ && dir_reg == '0, "query did not start reading at first neighbor")
    `ASSERT_IMPL(a_load_free, clk, rst_n, cmd.load_out, status.out_free, "result loaded over a waiting item")

endmodule

FILE: rtl/core/lgnc_dp.sv
`include "assert_macros.svh"

module lgnc_dp
    import lgnc_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    input  lgnc_cmd_t             cmd,
    output lgnc_status_t          status
);

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int AW      = $clog2(DEPTH);
    localparam int ROW_CAP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
    localparam int COL_CAP = (MAX_COLS > 127) ? 127 : MAX_COLS;

    localparam logic [CFG_W-1:0]   ROW_CAP_V  = CFG_W'(ROW_CAP);
    localparam logic [CFG_W-1:0]   COL_CAP_V  = CFG_W'(COL_CAP);
    localparam logic [CFG_W-1:0]   MIN_SIZE   = CFG_W'(2);
    localparam logic [AW-1:0]      ADDR_LAST  = AW'(DEPTH - 1);
    localparam logic [AW-1:0]      COL_STRIDE = AW'(MAX_COLS);
    localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(8);

    localparam logic [1:0] OFS_DEC  = 2'd0;
    localparam logic [1:0] OFS_HOLD = 2'd1;
    localparam logic [1:0] OFS_INC  = 2'd2;

    localparam logic [1:0] DIR_DR [8] = '{OFS_DEC, OFS_DEC, OFS_DEC, OFS_HOLD,
                                          OFS_HOLD, OFS_INC, OFS_INC, OFS_INC};
    localparam logic [1:0] DIR_DC [8] = '{OFS_DEC, OFS_HOLD, OFS_INC, OFS_DEC,
                                          OFS_INC, OFS_DEC, OFS_HOLD, OFS_INC};

    typedef struct packed {
        logic [CFG_W-1:0] pos;
        logic             on_grid;
    } axis_t;

    // one coordinate step under the edge rule; pos lies on the grid
    function automatic axis_t axis_step(input logic [CFG_W-1:0]  pos,
                                        input logic [CFG_W-1:0]  size,
                                        input logic [1:0]        ofs,
                                        input logic [MODE_W-1:0] mode);
        axis_t            res;
        logic [CFG_W-1:0] last;
        last        = size - CFG_W'(1);
        res.pos     = pos;
        res.on_grid = 1'b1;
        case (ofs)
            OFS_DEC:
            begin
                if (pos == '0)
                begin
                    case (mode)
                        MODE_WRAP:   res.pos = last;
                        MODE_MIRROR: res.pos = pos;
                        default:     res.on_grid = 1'b0;
                    endcase
                end
                else
                begin
                    res.pos = pos - CFG_W'(1);
                end
            end
            OFS_INC:
            begin
                if (pos == last)
                begin
                    case (mode)
                        MODE_WRAP:   res.pos = '0;
                        MODE_MIRROR: res.pos = pos;
                        default:     res.on_grid = 1'b0;
                    endcase
                end
                else
                begin
                    res.pos = pos + CFG_W'(1);
                end
            end
            default:
            begin
                res.pos = pos;
            end
        endcase
        return res;
    endfunction

    logic [CFG_W-1:0]   rows_reg;
    logic [CFG_W-1:0]   cols_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [CFG_W-1:0]   rows_use;
    logic [CFG_W-1:0]   cols_use;

    logic               in_op;
    logic [COORD_W-1:0] in_row;
    logic [COORD_W-1:0] in_col;
    logic               in_occ;
    logic               in_accept;
    logic               in_inside;
    logic [AW-1:0]      in_addr;

    logic [CFG_W-1:0]   q_row_reg;
    logic [CFG_W-1:0]   q_col_reg;
    logic               q_inside_reg;

    axis_t              nbr_row;
    axis_t              nbr_col;
    logic [AW-1:0]      rd_addr;

    logic               grid_mem [DEPTH];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic               mem_wdata;
    logic [AW-1:0]      clear_cnt_reg;

    logic               rd_bit_reg;
    logic               rd_mask_reg;
    logic               rd_vld_reg;
    logic [COUNT_W-1:0] acc_reg;

    logic               m_tvalid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               oor_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFG_W'(64);
            cols_reg <= CFG_W'(64);
            mode_reg <= MODE_CLASSIC;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROWS: rows_reg <= cfg_data;
                CFG_COLS: cols_reg <= cfg_data;
                CFG_MODE: mode_reg <= cfg_data[MODE_W-1:0];
                default:  ;
            endcase
        end
    end

    assign rows_use = (rows_reg < MIN_SIZE) ? MIN_SIZE :
                      ((rows_reg > ROW_CAP_V) ? ROW_CAP_V : rows_reg);
    assign cols_use = (cols_reg < MIN_SIZE) ? MIN_SIZE :
                      ((cols_reg > COL_CAP_V) ? COL_CAP_V : cols_reg);

    // input item
    assign in_op  = s_tuser;
    assign in_row = s_tdata[COORD_W-1:0];
    assign in_col = s_tdata[2*COORD_W-1:COORD_W];
    assign in_occ = s_tdata[2*COORD_W];

    assign s_tready  = cmd.in_ready;
    assign in_accept = s_tvalid && cmd.in_ready;
    assign in_inside = ({1'b0, in_row} < rows_use) && ({1'b0, in_col} < cols_use);
    assign in_addr   = AW'(in_row) * COL_STRIDE + AW'(in_col);

    assign status.query_start  = in_accept && (in_op == OP_QUERY);
    assign status.query_inside = in_inside;
    assign status.clear_last   = (clear_cnt_reg == ADDR_LAST);
    assign status.out_free     = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (status.query_start)
        begin
            q_row_reg    <= {1'b0, in_row};
            q_col_reg    <= {1'b0, in_col};
            q_inside_reg <= in_inside;
        end
    end

    // neighbor address
    assign nbr_row = axis_step(q_row_reg, rows_use, DIR_DR[cmd.read_dir], mode_reg);
    assign nbr_col = axis_step(q_col_reg, cols_use, DIR_DC[cmd.read_dir], mode_reg);
    assign rd_addr = AW'(nbr_row.pos) * COL_STRIDE + AW'(nbr_col.pos);

    // grid memory
    assign mem_we    = cmd.clear_en || (in_accept && (in_op == OP_WRITE) && in_inside);
    assign mem_waddr = cmd.clear_en ? clear_cnt_reg : in_addr;
    assign mem_wdata = !cmd.clear_en && in_occ;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read_en)
        begin
            rd_bit_reg  <= grid_mem[rd_addr];
            rd_mask_reg <= nbr_row.on_grid && nbr_col.on_grid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clear_cnt_reg <= clear_cnt_reg + AW'(1);
        end
    end

    // neighbor count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.read_en;
            if (status.query_start)
            begin
                acc_reg <= '0;
            end
            else if (rd_vld_reg && rd_mask_reg && rd_bit_reg)
            begin
                acc_reg <= acc_reg + COUNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            count_reg <= q_inside_reg ? acc_reg : '0;
            oor_reg   <= !q_inside_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-COUNT_W){1'b0}}, count_reg};
    assign m_tuser  = oor_reg;

    `ASSERT_IMPL(a_count_max, clk, rst_n, m_tvalid_reg, count_reg <= MAX_COUNT, "neighbor count above eight")
    `ASSERT_IMPL(a_oor_zero, clk, rst_n, m_tvalid_reg && oor_reg, count_reg == '0, "out of range result with nonzero count")
    `ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.load_out, m_tvalid_reg, "loaded result not presented")

endmodule

FILE: rtl/core/life_grid_neighbor_counter.sv
// Occupancy grid with neighbor counting under a selectable edge rule (classic, wrap, mirror).
// A write item stores one cell if it lies inside the grid. A query item returns the count of
// occupied neighbors; the eight neighbor bits are read one per cycle from the single-port
// grid memory, so a query holds the input through its accept, the eight reads, a drain state
// and a load state that waits while an earlier result is unread, before the next item is
// taken. The result waits in its own register, so the next item can start while it is unread.
// After reset the grid memory is cleared one cell per cycle with s_tready low; configuration
// writes are taken throughout. A query outside the grid skips the reads and reports out of range.

module life_grid_neighbor_counter
    import lgnc_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // row[5:0], col[11:6], occupied[12], zero pad
    input  logic                  s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // neighbor_count[3:0], zero pad
    output logic                  m_tuser    // out_of_range
);

    lgnc_cmd_t    cmd;
    lgnc_status_t status;

    lgnc_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    lgnc_dp
    #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: tb/life_grid_count_checker.sv
`timescale 1ns / 100ps

module life_grid_count_checker
    import lgnc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    output int                    fail_count,
    output int                    pending
);

    localparam int GRID_ROWS  = 64;
    localparam int GRID_COLS  = 64;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               outside;
    } count_result_t;

    logic               grid [GRID_ROWS][GRID_COLS];
    logic [CFG_W-1:0]   rows_reg;
    logic [CFG_W-1:0]   cols_reg;
    logic [MODE_W-1:0]  mode_reg;
    count_result_t      expected_counts [$];
    count_result_t      oldest;
    int                 item_row;
    int                 item_col;

    function automatic int size_used(logic [CFG_W-1:0] value, int limit);
        if (value < 2)
            return 2;
        if (value > limit)
            return limit;
        return value;
    endfunction

    function automatic count_result_t predict_count(int r, int c);
        int            rows;
        int            cols;
        int            nr;
        int            nc;
        int            total;
        count_result_t res;
        rows  = size_used(rows_reg, GRID_ROWS);
        cols  = size_used(cols_reg, GRID_COLS);
        total = 0;
        res.outside = (r >= rows) || (c >= cols);
        res.count   = '0;
        if (res.outside)
            return res;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                if (dr != 0 || dc != 0)
                begin
                    nr = r + dr;
                    nc = c + dc;
                    if (mode_reg == MODE_WRAP)
                    begin
                        if (nr < 0) nr += rows;
                        if (nr >= rows) nr -= rows;
                        if (nc < 0) nc += cols;
                        if (nc >= cols) nc -= cols;
                        total += grid[nr][nc];
                    end
                    else if (mode_reg == MODE_MIRROR)
                    begin
                        if (nr < 0) nr = 0;
                        if (nr >= rows) nr = rows - 1;
                        if (nc < 0) nc = 0;
                        if (nc >= cols) nc = cols - 1;
                        total += grid[nr][nc];
                    end
                    else if (nr >= 0 && nr < rows && nc >= 0 && nc < cols)
                    begin
                        total += grid[nr][nc];
                    end
                end
            end
        end
        res.count = total[COUNT_W-1:0];
        return res;
    endfunction

    task automatic report(string what, int expected_value, int actual_value);
        $display("mismatch: %s expected %0d got %0d at %0t",
                 what, expected_value, actual_value, $time);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < GRID_ROWS; r++)
                for (int c = 0; c < GRID_COLS; c++)
                    grid[r][c] = 1'b0;
            rows_reg = 7'd64;
            cols_reg = 7'd64;
            mode_reg = MODE_CLASSIC;
            expected_counts.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROWS: rows_reg = cfg_data;
                    CFG_COLS: cols_reg = cfg_data;
                    CFG_MODE: mode_reg = cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_counts.size() == 0)
                begin
                    report("result with none pending", 0, 1);
                end
                else
                begin
                    oldest = expected_counts.pop_front();
                    if (m_tdata[COUNT_W-1:0] !== oldest.count)
                        report("neighbor_count", oldest.count, m_tdata[COUNT_W-1:0]);
                    if (m_tuser !== oldest.outside)
                        report("out_of_range", oldest.outside, m_tuser);
                end
            end

            if (s_tvalid && s_tready)
            begin
                item_row = s_tdata[COORD_W-1:0];
                item_col = s_tdata[2*COORD_W-1:COORD_W];
                if (s_tuser == OP_WRITE)
                begin
                    if (item_row < size_used(rows_reg, GRID_ROWS) &&
                        item_col < size_used(cols_reg, GRID_COLS))
                        grid[item_row][item_col] = s_tdata[2*COORD_W];
                end
                else
                begin
                    expected_counts.push_back(predict_count(item_row, item_col));
                end
            end

            pending = expected_counts.size();
        end
    end

endmodule

FILE: tb/life_grid_neighbor_counter_test.sv
`timescale 1ns / 100ps

module life_grid_neighbor_counter_test;

    import lgnc_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 165;
    localparam int PHASE_COUNT   = 11;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;
    int rows_used   = 64;
    int cols_used   = 64;

    always #10 clk = ~clk;

    life_grid_neighbor_counter DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    life_grid_count_checker u_count_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // result side stall pattern
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(50, 300);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_grid(int rows, int cols, logic [MODE_W-1:0] mode);
        write_reg(CFG_ROWS, CFG_W'(rows));
        write_reg(CFG_COLS, CFG_W'(cols));
        write_reg(CFG_MODE, CFG_W'(mode));
        cfg_valid <= 1'b0;
        rows_used = (rows < 2) ? 2 : ((rows > 64) ? 64 : rows);
        cols_used = (cols < 2) ? 2 : ((cols > 64) ? 64 : cols);
    endtask

    // hold off until every query has answered and the block is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(logic op, int row, int col, logic occ);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, occ, col[COORD_W-1:0], row[COORD_W-1:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
    endtask

    // coordinates lean toward the edges and one corner region
    function automatic int pick_coord(int size);
        case ($urandom_range(0, 15))
            0:       return $urandom_range(0, 63);
            1, 2:    return 0;
            3, 4:    return size - 1;
            5, 6:    return (size > 3) ? $urandom_range(size - 3, size - 1)
                                       : $urandom_range(0, size - 1);
            default: return $urandom_range(0, (size > 12) ? 11 : size - 1);
        endcase
    endfunction

    initial
    begin
        int               rows;
        int               cols;
        logic [MODE_W-1:0] mode;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        set_grid(64, 64, MODE_CLASSIC);
        send_item(OP_WRITE, 0, 0, 1'b1);
        send_item(OP_WRITE, 0, 1, 1'b1);
        send_item(OP_WRITE, 1, 0, 1'b1);
        send_item(OP_WRITE, 63, 63, 1'b1);
        send_item(OP_WRITE, 62, 63, 1'b1);
        send_item(OP_WRITE, 1, 1, 1'b0);
        send_item(OP_QUERY, 0, 0, 1'b0);
        send_item(OP_QUERY, 1, 1, 1'b1);
        send_item(OP_QUERY, 63, 63, 1'b0);
        send_item(OP_QUERY, 62, 62, 1'b0);
        send_item(OP_QUERY, 0, 63, 1'b0);
        settle();
        set_grid(64, 64, MODE_MIRROR);
        send_item(OP_QUERY, 0, 0, 1'b0);
        send_item(OP_QUERY, 63, 63, 1'b0);
        send_item(OP_QUERY, 63, 0, 1'b0);
        settle();
        set_grid(2, 2, MODE_WRAP);
        send_item(OP_QUERY, 0, 0, 1'b0);
        send_item(OP_QUERY, 1, 1, 1'b0);
        send_item(OP_WRITE, 5, 5, 1'b1);
        send_item(OP_QUERY, 5, 5, 1'b0);
        send_item(OP_QUERY, 63, 0, 1'b0);
        settle();
        // sizes beyond the limits and the unused edge rule
        set_grid(0, 127, MODE_W'(3));
        send_item(OP_QUERY, 1, 63, 1'b0);
        send_item(OP_QUERY, 0, 0, 1'b0);
        send_item(OP_QUERY, 2, 0, 1'b0);
        settle();

        // random
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: begin rows = 64; cols = 64; mode = MODE_WRAP;    end
                1: begin rows = 64; cols = 64; mode = MODE_MIRROR;  end
                2: begin rows = 2;  cols = 2;  mode = MODE_WRAP;    end
                3: begin rows = 2;  cols = 64; mode = MODE_MIRROR;  end
                4: begin rows = 64; cols = 2;  mode = MODE_CLASSIC; end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: rows = $urandom_range(0, 127);
                        1: rows = 64;
                        default: rows = $urandom_range(2, 10);
                    endcase
                    case ($urandom_range(0, 3))
                        0: cols = $urandom_range(0, 127);
                        1: cols = 64;
                        default: cols = $urandom_range(2, 10);
                    endcase
                    mode = MODE_W'($urandom_range(0, 3));
                end
            endcase
            set_grid(rows, cols, mode);
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 299) == 0)
                    settle();
                send_item(1'($urandom_range(0, 1)), pick_coord(rows_used),
                          pick_coord(cols_used), 1'($urandom_range(0, 1)));
            end
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/lgnc_pkg.sv
rtl/core/lgnc_ctrl.sv
rtl/core/lgnc_dp.sv
rtl/core/life_grid_neighbor_counter.sv
tb/life_grid_count_checker.sv
tb/life_grid_neighbor_counter_test.sv
